[src/dwr_pkg.sv]
package dwr_pkg;

   // Default frame memory geometry.
   localparam int COLUMNS_DEF = 240;
   localparam int ROWS_DEF    = 320;

   // Fixed field widths.
   localparam int CMD_W       = 2;
   localparam int COL_FIELD_W = 8;
   localparam int ROW_FIELD_W = 9;
   localparam int PIX_W       = 16;
   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   // Width for row arithmetic on the scroll mapping (holds twice the largest row count).
   localparam int DIM_W = 11;

   // Field positions inside req_tdata.
   localparam int LEFT_LSB   = 0;
   localparam int TOP_LSB    = 8;
   localparam int RIGHT_LSB  = 17;
   localparam int BOTTOM_LSB = 25;
   localparam int PIX_LSB    = 34;
   localparam int SCROLL_LSB = 50;
   localparam int RROW_LSB   = 59;
   localparam int RCOL_LSB   = 68;

   localparam logic [ROW_FIELD_W-1:0] SCROLL_AREA_RESET = 9'd320;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET_WINDOW  = 2'd0,
      CMD_WRITE_PIXEL = 2'd1,
      CMD_SET_SCROLL  = 2'd2,
      CMD_READ_PIXEL  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FILL_BY_ROW  = 2'd0,
      REG_INVERT       = 2'd1,
      REG_TOP_FIXED    = 2'd2,
      REG_SCROLL_AREA  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic addr;
      logic mem_write;
      logic mem_read;
      logic load_rsp;
      logic clear_step;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    clear_last;
      logic    rsp_free;
   } dp_status_type;

endpackage

[src/dwr_ctrl.sv]
module dwr_ctrl
   import dwr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type stat,
   output dp_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_CALC   = 6'b000100,
      ST_ADDR   = 6'b001000,
      ST_ACCESS = 6'b010000,
      ST_LOAD   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            if (stat.cmd == CMD_WRITE_PIXEL || stat.cmd == CMD_READ_PIXEL) begin
               state_in = ST_ADDR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ADDR: begin
            cmd.addr = 1'b1;
            state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            if (stat.cmd == CMD_WRITE_PIXEL) begin
               cmd.mem_write = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.mem_read = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // Hold here until the result register has room.
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/dwr_datapath.sv]
module dwr_datapath
   import dwr_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CMD_W-1:0]       req_tuser,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  dp_cmd_type             cmd,
   output dp_status_type          stat
);

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLUMNS);

   // Configuration registers.
   logic                   fill_by_row_ff;
   logic                   invert_ff;
   logic [ROW_FIELD_W-1:0] top_fixed_ff;
   logic [ROW_FIELD_W-1:0] scroll_area_ff;

   // Window, cursor and scroll state.
   logic [COL_FIELD_W-1:0] win_left_ff, win_left_in;
   logic [ROW_FIELD_W-1:0] win_top_ff, win_top_in;
   logic [COL_FIELD_W-1:0] win_right_ff, win_right_in;
   logic [ROW_FIELD_W-1:0] win_bottom_ff, win_bottom_in;
   logic [COL_FIELD_W-1:0] cursor_col_ff, cursor_col_in;
   logic [ROW_FIELD_W-1:0] cursor_row_ff, cursor_row_in;
   logic                   cursor_out_ff, cursor_out_in;
   logic [ROW_FIELD_W-1:0] scroll_start_ff, scroll_start_in;

   // Captured word.
   cmd_type               cmd_ff;
   logic [REQ_DATA_W-1:0] req_data_ff;

   // Scroll geometry, refreshed every cycle from the registers.
   logic [DIM_W-1:0] tfa, room, vsa, area_end, start_raw, start_eff;
   logic [DIM_W-1:0] tfa_ff, vsa_ff, end_ff, start_ff;

   // Access pipeline.
   logic [ROW_W-1:0] row_sel_ff;
   logic [COL_W-1:0] col_sel_ff;
   logic             access_ok_ff;
   logic [AW-1:0]    addr_ff;
   logic [AW-1:0]    clr_cnt_ff;
   logic [PIX_W-1:0] rdata_ff;
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_data_ff;

   logic [PIX_W-1:0] frame_mem [DEPTH];

   // Field slices.
   logic [COL_FIELD_W-1:0] f_left, f_right, f_rcol;
   logic [ROW_FIELD_W-1:0] f_top, f_bottom, f_scroll, f_rrow;
   logic [PIX_W-1:0]       f_pix;

   // Per-item decisions.
   logic             in_win, store_ok, in_scroll, read_ok;
   logic [DIM_W-1:0] row_w, sum, mem_row;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [PIX_W-1:0] mem_wdata;

   assign f_left   = req_data_ff[LEFT_LSB   +: COL_FIELD_W];
   assign f_top    = req_data_ff[TOP_LSB    +: ROW_FIELD_W];
   assign f_right  = req_data_ff[RIGHT_LSB  +: COL_FIELD_W];
   assign f_bottom = req_data_ff[BOTTOM_LSB +: ROW_FIELD_W];
   assign f_pix    = req_data_ff[PIX_LSB    +: PIX_W];
   assign f_scroll = req_data_ff[SCROLL_LSB +: ROW_FIELD_W];
   assign f_rrow   = req_data_ff[RROW_LSB   +: ROW_FIELD_W];
   assign f_rcol   = req_data_ff[RCOL_LSB   +: COL_FIELD_W];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_by_row_ff <= 1'b0;
         invert_ff      <= 1'b0;
         top_fixed_ff   <= '0;
         scroll_area_ff <= SCROLL_AREA_RESET;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_FILL_BY_ROW: fill_by_row_ff <= csr_data[0];
            REG_INVERT:      invert_ff      <= csr_data[0];
            REG_TOP_FIXED:   top_fixed_ff   <= csr_data;
            REG_SCROLL_AREA: scroll_area_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Top area saturates to the display, scroll area to the rows left below it.
   // A scroll start outside the scroll area falls back to its first row.
   always_comb begin
      tfa       = (DIM_W'(top_fixed_ff) > DIM_W'(ROWS)) ? DIM_W'(ROWS) : DIM_W'(top_fixed_ff);
      room      = DIM_W'(ROWS) - tfa;
      vsa       = (DIM_W'(scroll_area_ff) > room) ? room : DIM_W'(scroll_area_ff);
      area_end  = tfa + vsa;
      start_raw = DIM_W'(scroll_start_ff);
      start_eff = (start_raw < tfa || start_raw >= area_end) ? tfa : start_raw;
   end

   always_ff @(posedge clock) begin
      tfa_ff   <= tfa;
      vsa_ff   <= vsa;
      end_ff   <= area_end;
      start_ff <= start_eff;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_data_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= CMD_SET_WINDOW;
      end else if (cmd.capture) begin
         cmd_ff <= cmd_type'(req_tuser);
      end
   end

   assign in_win = !cursor_out_ff &&
                   cursor_col_ff >= win_left_ff && cursor_col_ff <= win_right_ff &&
                   cursor_row_ff >= win_top_ff  && cursor_row_ff <= win_bottom_ff;
   assign store_ok = in_win && DIM_W'(cursor_col_ff) < DIM_W'(COLUMNS) &&
                     DIM_W'(cursor_row_ff) < DIM_W'(ROWS);

   always_comb begin
      win_left_in     = win_left_ff;
      win_top_in      = win_top_ff;
      win_right_in    = win_right_ff;
      win_bottom_in   = win_bottom_ff;
      cursor_col_in   = cursor_col_ff;
      cursor_row_in   = cursor_row_ff;
      cursor_out_in   = cursor_out_ff;
      scroll_start_in = scroll_start_ff;
      if (cmd.calc) begin
         case (cmd_ff)
            CMD_SET_WINDOW: begin
               win_left_in   = f_left;
               win_top_in    = f_top;
               win_right_in  = f_right;
               win_bottom_in = f_bottom;
               cursor_col_in = f_left;
               cursor_row_in = f_top;
               cursor_out_in = 1'b0;
            end
            CMD_SET_SCROLL: begin
               scroll_start_in = f_scroll;
            end
            CMD_WRITE_PIXEL: begin
               if (in_win) begin
                  if (fill_by_row_ff) begin
                     if (cursor_col_ff >= win_right_ff) begin
                        cursor_col_in = win_left_ff;
                        if (cursor_row_ff >= win_bottom_ff) begin
                           cursor_out_in = 1'b1;
                        end else begin
                           cursor_row_in = cursor_row_ff + 1'b1;
                        end
                     end else begin
                        cursor_col_in = cursor_col_ff + 1'b1;
                     end
                  end else begin
                     if (cursor_row_ff >= win_bottom_ff) begin
                        cursor_row_in = win_top_ff;
                        if (cursor_col_ff >= win_right_ff) begin
                           cursor_out_in = 1'b1;
                        end else begin
                           cursor_col_in = cursor_col_ff + 1'b1;
                        end
                     end else begin
                        cursor_row_in = cursor_row_ff + 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff     <= '0;
         win_top_ff      <= '0;
         win_right_ff    <= '0;
         win_bottom_ff   <= '0;
         cursor_col_ff   <= '0;
         cursor_row_ff   <= '0;
         cursor_out_ff   <= 1'b0;
         scroll_start_ff <= '0;
      end else begin
         win_left_ff     <= win_left_in;
         win_top_ff      <= win_top_in;
         win_right_ff    <= win_right_in;
         win_bottom_ff   <= win_bottom_in;
         cursor_col_ff   <= cursor_col_in;
         cursor_row_ff   <= cursor_row_in;
         cursor_out_ff   <= cursor_out_in;
         scroll_start_ff <= scroll_start_in;
      end
   end

   // Display row to memory row: scrolled rows wrap inside the scroll area.
   always_comb begin
      row_w     = DIM_W'(f_rrow);
      read_ok   = row_w < DIM_W'(ROWS) && DIM_W'(f_rcol) < DIM_W'(COLUMNS);
      in_scroll = row_w >= tfa_ff && row_w < end_ff;
      sum       = start_ff + (row_w - tfa_ff);
      if (!in_scroll) begin
         mem_row = row_w;
      end else if (sum >= end_ff) begin
         mem_row = sum - vsa_ff;
      end else begin
         mem_row = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         if (cmd_ff == CMD_READ_PIXEL) begin
            row_sel_ff   <= ROW_W'(mem_row);
            col_sel_ff   <= COL_W'(f_rcol);
            access_ok_ff <= read_ok;
         end else begin
            row_sel_ff   <= ROW_W'(cursor_row_ff);
            col_sel_ff   <= COL_W'(cursor_col_ff);
            access_ok_ff <= store_ok;
         end
      end
      if (cmd.addr) begin
         addr_ff <= AW'(row_sel_ff) * AW'(COLUMNS) + AW'(col_sel_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign mem_we    = cmd.clear_step || (cmd.mem_write && access_ok_ff);
   assign mem_waddr = cmd.clear_step ? clr_cnt_ff : addr_ff;
   assign mem_wdata = cmd.clear_step ? '0 : f_pix;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.mem_read && access_ok_ff) begin
         rdata_ff <= frame_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (!access_ok_ff) begin
            rsp_data_ff <= '0;
         end else if (invert_ff) begin
            rsp_data_ff <= ~rdata_ff;
         end else begin
            rsp_data_ff <= rdata_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign stat.cmd        = cmd_ff;
   assign stat.clear_last = clr_cnt_ff == AW'(DEPTH - 1);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_tready;

endmodule

[src/display_ram_window_writer.sv]
// Channel  Direction  Handshake             Payload
// req      in         req_tvalid/tready     tuser: command; tdata: window, pixel, scroll, read
// rsp      out        rsp_tvalid/tready     tdata: pixel_out
// csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// Set window and set scroll pass the capture and calculate steps; a pixel write
// adds the address and access steps, a pixel read also a load step that waits
// for room in the result register. No word is accepted until the last is done.
// After reset a clearing pass writes zero to all ROWS*COLUMNS words, one word a
// cycle (76800 words by default); no word is accepted meanwhile, csr writes are.
// A pending result may wait in its register while further words are accepted.
module display_ram_window_writer
   import dwr_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [CMD_W-1:0]       req_tuser,  // command
   // win_left, win_top, win_right, win_bottom, pixel_in, scroll_start, read_row, read_col
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,  // pixel_out
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   dwr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dwr_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

[src/dwr_checker.sv]
module dwr_checker
   import dwr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [CMD_W-1:0]       req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata
);

   logic req_acc;
   assign req_acc = req_tvalid && req_tready;

   // A stalled result word keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Every accepted word keeps the block busy, so input is never accepted back to back.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("input accepted on two consecutive cycles");

   // Commands other than a read never produce a result word.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tuser != CMD_READ_PIXEL |=> !$rose(rsp_tvalid) ##1 !$rose(rsp_tvalid))
      else $error("result word without a read");

   // A read accepted with an empty result register passes the load step without a stall.
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tuser == CMD_READ_PIXEL && !rsp_tvalid |-> ##5 rsp_tvalid)
      else $error("read result missing");

endmodule

bind display_ram_window_writer dwr_checker u_dwr_checker (.*);

[tb/display_ram_window_writer_tb.sv]
module display_ram_window_writer_tb
   import dwr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF     = 6;
   localparam int FRAME_COLS   = COLUMNS_DEF;
   localparam int FRAME_ROWS   = ROWS_DEF;
   localparam int LIMIT_CYCLES = 600000;
   localparam int PHASE_WORDS  = 128;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  left;
      logic [8:0]  top;
      logic [7:0]  right;
      logic [8:0]  bottom;
      logic [15:0] pixel;
      logic [8:0]  scroll;
      logic [8:0]  row;
      logic [7:0]  col;
   } gram_word_type;

   typedef struct packed {
      gram_word_type w;
      logic          typed;
      logic [15:0]   typed_pix;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [CMD_W-1:0]       req_tuser = '0;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Shadow copy of the frame memory, write cursor and settings.
   logic [15:0] gram_model [0:FRAME_ROWS*FRAME_COLS-1];
   int          cur_col = 0;
   int          cur_row = 0;
   bit          cur_out = 1'b0;
   int          win_l = 0;
   int          win_t = 0;
   int          win_r = 0;
   int          win_b = 0;
   int          scroll_start_q = 0;
   bit          cfg_fill_by_row = 1'b0;
   bit          cfg_invert = 1'b0;
   int          cfg_top_fixed = 0;
   int          cfg_scroll_area = 320;

   logic [15:0]      pixel_expect_q [$];
   directed_row_type directed_tbl [25];
   int               mismatches = 0;
   int               words_counted = 0;
   int               reads_sent = 0;
   bit               quiet = 1'b0;

   display_ram_window_writer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   // Memory row shown at a display row once the fixed areas and scroll are applied.
   function automatic int shown_mem_row(int r);
      int tfa;
      int vsa;
      int ending;
      int start;
      int mr;
      tfa = (cfg_top_fixed > FRAME_ROWS) ? FRAME_ROWS : cfg_top_fixed;
      vsa = (cfg_scroll_area > FRAME_ROWS - tfa) ? FRAME_ROWS - tfa : cfg_scroll_area;
      ending = tfa + vsa;
      mr = r;
      if (r >= tfa && r < ending) begin
         start = scroll_start_q;
         if (start < tfa || start >= ending)
            start = tfa;
         mr = start + (r - tfa);
         if (mr >= ending)
            mr -= vsa;
      end
      return mr;
   endfunction

   function automatic logic [15:0] displayed_pixel(int r, int c);
      logic [15:0] v;
      if (r >= FRAME_ROWS || c >= FRAME_COLS)
         return '0;
      v = gram_model[shown_mem_row(r) * FRAME_COLS + c];
      return cfg_invert ? ~v : v;
   endfunction

   // Applies one accepted word to the shadow state. A write that lands nowhere
   // and moves nothing is not counted as stimulus.
   function automatic void advance_gram_model(input gram_word_type w, output bit has_pixel,
                                              output logic [15:0] pix, output bit counted);
      has_pixel = 1'b0;
      pix = '0;
      counted = 1'b1;
      case (w.cmd)
         CMD_SET_WINDOW: begin
            win_l = w.left;
            win_t = w.top;
            win_r = w.right;
            win_b = w.bottom;
            cur_col = win_l;
            cur_row = win_t;
            cur_out = 1'b0;
         end
         CMD_WRITE_PIXEL: begin
            if (cur_out || cur_col < win_l || cur_col > win_r ||
                cur_row < win_t || cur_row > win_b) begin
               counted = 1'b0;
            end else begin
               if (cur_col < FRAME_COLS && cur_row < FRAME_ROWS)
                  gram_model[cur_row * FRAME_COLS + cur_col] = w.pixel;
               if (cfg_fill_by_row) begin
                  if (cur_col >= win_r) begin
                     cur_col = win_l;
                     if (cur_row >= win_b)
                        cur_out = 1'b1;
                     else
                        cur_row++;
                  end else begin
                     cur_col++;
                  end
               end else begin
                  if (cur_row >= win_b) begin
                     cur_row = win_t;
                     if (cur_col >= win_r)
                        cur_out = 1'b1;
                     else
                        cur_col++;
                  end else begin
                     cur_row++;
                  end
               end
            end
         end
         CMD_SET_SCROLL: begin
            scroll_start_q = w.scroll;
         end
         default: begin
            has_pixel = 1'b1;
            pix = displayed_pixel(w.row, w.col);
         end
      endcase
   endfunction

   function automatic directed_row_type drow(cmd_type cmd, int a, int b, int c, int d,
                                             bit typed, logic [15:0] pix);
      directed_row_type t;
      t = '0;
      t.w.cmd = cmd;
      t.typed = typed;
      t.typed_pix = pix;
      case (cmd)
         CMD_SET_WINDOW: begin
            t.w.left = 8'(a);
            t.w.top = 9'(b);
            t.w.right = 8'(c);
            t.w.bottom = 9'(d);
         end
         CMD_WRITE_PIXEL: t.w.pixel = 16'(a);
         CMD_SET_SCROLL: t.w.scroll = 9'(a);
         default: begin
            t.w.row = 9'(a);
            t.w.col = 8'(b);
         end
      endcase
      return t;
   endfunction

   // Fields the command does not use are random too, so every bit toggles.
   function automatic gram_word_type random_word();
      gram_word_type w;
      w.cmd = cmd_type'($urandom_range(0, 3));
      w.left = 8'($urandom);
      w.top = 9'($urandom);
      w.right = 8'($urandom);
      w.bottom = 9'($urandom);
      w.pixel = 16'($urandom);
      w.scroll = 9'($urandom);
      w.row = 9'($urandom);
      w.col = 8'($urandom);
      return w;
   endfunction

   task automatic send_word(input gram_word_type w, input bit typed,
                            input logic [15:0] typed_pix);
      logic [REQ_DATA_W-1:0] d;
      bit                    has_pixel;
      logic [15:0]           pix;
      bit                    counted;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      d = '0;
      d[LEFT_LSB +: COL_FIELD_W] = w.left;
      d[TOP_LSB +: ROW_FIELD_W] = w.top;
      d[RIGHT_LSB +: COL_FIELD_W] = w.right;
      d[BOTTOM_LSB +: ROW_FIELD_W] = w.bottom;
      d[PIX_LSB +: PIX_W] = w.pixel;
      d[SCROLL_LSB +: ROW_FIELD_W] = w.scroll;
      d[RROW_LSB +: ROW_FIELD_W] = w.row;
      d[RCOL_LSB +: COL_FIELD_W] = w.col;
      req_tvalid <= 1'b1;
      req_tuser <= w.cmd;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      advance_gram_model(w, has_pixel, pix, counted);
      if (has_pixel) begin
         pixel_expect_q.push_back(typed ? typed_pix : pix);
         reads_sent++;
      end
      if (counted)
         words_counted++;
   endtask

   // Set a window, fill part or all of it, then read back pixels that it holds when it lies in the memory.
   task automatic window_burst();
      gram_word_type w;
      int            wd;
      int            ht;
      int            mr;
      int            disp_row;
      w = random_word();
      w.cmd = CMD_SET_WINDOW;
      wd = $urandom_range(1, 6);
      ht = $urandom_range(1, 6);
      if ($urandom_range(0, 9) < 8) begin
         w.left = 8'($urandom_range(0, FRAME_COLS - wd));
         w.top = 9'($urandom_range(0, FRAME_ROWS - ht));
         w.right = 8'(w.left + wd - 1);
         w.bottom = 9'(w.top + ht - 1);
      end else if ($urandom_range(0, 1) == 0) begin
         // Reaches past the memory edge, so part or all of the fill stores nothing.
         w.left = 8'($urandom_range(FRAME_COLS - 4, 255));
         w.top = 9'($urandom_range(FRAME_ROWS - 4, 511));
         w.right = 8'(255);
         w.bottom = 9'(511);
      end
      send_word(w, 1'b0, '0);
      repeat ($urandom_range(1, wd * ht + 2)) begin
         w = random_word();
         w.cmd = CMD_WRITE_PIXEL;
         send_word(w, 1'b0, '0);
      end
      repeat ($urandom_range(1, 4)) begin
         w = random_word();
         w.cmd = CMD_READ_PIXEL;
         if (win_l <= win_r && win_t <= win_b && win_r < FRAME_COLS && win_b < FRAME_ROWS) begin
            mr = $urandom_range(win_t, win_b);
            disp_row = mr;
            // Find a display row that shows this memory row under the current scroll.
            for (int r = FRAME_ROWS - 1; r >= 0; r--)
               if (shown_mem_row(r) == mr)
                  disp_row = r;
            w.row = 9'(disp_row);
            w.col = 8'($urandom_range(win_l, win_r));
         end
         send_word(w, 1'b0, '0);
      end
   endtask

   task automatic run_phase(input int quota);
      gram_word_type w;
      int            first;
      int            kind;
      first = words_counted;
      while (words_counted - first < quota) begin
         kind = $urandom_range(0, 99);
         w = random_word();
         if (kind < 65) begin
            window_burst();
         end else if (kind < 80) begin
            w.cmd = CMD_SET_SCROLL;
            case ($urandom_range(0, 3))
               0: w.scroll = 9'(cfg_top_fixed);
               1: w.scroll = 9'((cfg_top_fixed + cfg_scroll_area > 511) ?
                                511 : cfg_top_fixed + cfg_scroll_area);
               2: w.scroll = 9'($urandom_range(0, FRAME_ROWS));
               default: ;
            endcase
            send_word(w, 1'b0, '0);
         end else if (kind < 93) begin
            w.cmd = CMD_READ_PIXEL;
            if ($urandom_range(0, 9) < 7) begin
               w.row = 9'($urandom_range(0, FRAME_ROWS - 1));
               w.col = 8'($urandom_range(0, FRAME_COLS - 1));
            end
            send_word(w, 1'b0, '0);
         end else begin
            send_word(w, 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_FILL_BY_ROW: cfg_fill_by_row = val[0];
         REG_INVERT:      cfg_invert = val[0];
         REG_TOP_FIXED:   cfg_top_fixed = val;
         default:         cfg_scroll_area = val;
      endcase
   endtask

   // Settings change only once the block has drained; the wait after the last
   // result lets a trailing pixel write finish.
   task automatic configure(input bit fill, input bit inv, input int tfa, input int vsa);
      while (pixel_expect_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      write_csr(REG_FILL_BY_ROW, CSR_DATA_W'(fill));
      write_csr(REG_INVERT, CSR_DATA_W'(inv));
      write_csr(REG_TOP_FIXED, CSR_DATA_W'(tfa));
      write_csr(REG_SCROLL_AREA, CSR_DATA_W'(vsa));
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : rsp_check
      logic [15:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_expect_q.size() == 0) begin
            $display("%0t: unexpected pixel word, expected none, got %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pixel_expect_q.pop_front();
            if (rsp_tdata !== want) begin
               $display("%0t: pixel_out mismatch, expected %h, got %h", $time, want, rsp_tdata);
               mismatches++;
            end
         end
      end
   end

   initial begin : rsp_drain
      bit held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (quiet) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if (!held && reads_sent >= 60) begin
            // One long hold-off so pending reads back up into the input.
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * 2 * CLK_HALF);
      $display("display_ram_window_writer regression: fail");
      $finish;
   end

   initial begin : stimulus
      foreach (gram_model[i])
         gram_model[i] = '0;

      // Reset state reads, a 2x2 column-first fill, dropped writes, a window
      // that cannot hold its cursor, one that runs past the memory, and scroll
      // starts inside and outside the scroll area.
      directed_tbl[0]  = drow(CMD_READ_PIXEL, 0, 0, 0, 0, 1'b1, 16'h0000);
      directed_tbl[1]  = drow(CMD_READ_PIXEL, 320, 0, 0, 0, 1'b1, 16'h0000);
      directed_tbl[2]  = drow(CMD_READ_PIXEL, 511, 255, 0, 0, 1'b1, 16'h0000);
      directed_tbl[3]  = drow(CMD_SET_WINDOW, 0, 0, 1, 1, 1'b0, '0);
      directed_tbl[4]  = drow(CMD_WRITE_PIXEL, 16'hFFFF, 0, 0, 0, 1'b0, '0);
      directed_tbl[5]  = drow(CMD_WRITE_PIXEL, 16'h0001, 0, 0, 0, 1'b0, '0);
      directed_tbl[6]  = drow(CMD_WRITE_PIXEL, 16'h8000, 0, 0, 0, 1'b0, '0);
      directed_tbl[7]  = drow(CMD_WRITE_PIXEL, 16'h1234, 0, 0, 0, 1'b0, '0);
      directed_tbl[8]  = drow(CMD_WRITE_PIXEL, 16'h5555, 0, 0, 0, 1'b0, '0);
      directed_tbl[9]  = drow(CMD_READ_PIXEL, 0, 0, 0, 0, 1'b1, 16'hFFFF);
      directed_tbl[10] = drow(CMD_READ_PIXEL, 1, 0, 0, 0, 1'b1, 16'h0001);
      directed_tbl[11] = drow(CMD_READ_PIXEL, 0, 1, 0, 0, 1'b1, 16'h8000);
      directed_tbl[12] = drow(CMD_READ_PIXEL, 1, 1, 0, 0, 1'b1, 16'h1234);
      directed_tbl[13] = drow(CMD_READ_PIXEL, 0, 2, 0, 0, 1'b1, 16'h0000);
      directed_tbl[14] = drow(CMD_SET_WINDOW, 10, 5, 3, 9, 1'b0, '0);
      directed_tbl[15] = drow(CMD_WRITE_PIXEL, 16'hAAAA, 0, 0, 0, 1'b0, '0);
      directed_tbl[16] = drow(CMD_READ_PIXEL, 5, 10, 0, 0, 1'b1, 16'h0000);
      directed_tbl[17] = drow(CMD_SET_WINDOW, 238, 318, 255, 511, 1'b0, '0);
      directed_tbl[18] = drow(CMD_WRITE_PIXEL, 16'h0F0F, 0, 0, 0, 1'b0, '0);
      directed_tbl[19] = drow(CMD_WRITE_PIXEL, 16'hF0F0, 0, 0, 0, 1'b0, '0);
      directed_tbl[20] = drow(CMD_WRITE_PIXEL, 16'h5A5A, 0, 0, 0, 1'b0, '0);
      directed_tbl[21] = drow(CMD_SET_SCROLL, 5, 0, 0, 0, 1'b0, '0);
      directed_tbl[22] = drow(CMD_READ_PIXEL, 0, 0, 0, 0, 1'b0, '0);
      directed_tbl[23] = drow(CMD_SET_SCROLL, 400, 0, 0, 0, 1'b0, '0);
      directed_tbl[24] = drow(CMD_READ_PIXEL, 318, 238, 0, 0, 1'b0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_tbl[i])
         send_word(directed_tbl[i].w, directed_tbl[i].typed, directed_tbl[i].typed_pix);

      run_phase(PHASE_WORDS);
      configure(1'b1, 1'b1, 0, 320);
      run_phase(PHASE_WORDS);
      configure(1'b1, 1'b0, 320, 0);
      run_phase(PHASE_WORDS);
      configure(1'b0, 1'b1, 511, 511);
      run_phase(PHASE_WORDS);
      configure(1'b1, 1'b0, 40, 200);
      run_phase(PHASE_WORDS);
      configure(1'b0, 1'b0, 100, 511);
      run_phase(PHASE_WORDS);
      configure(1'($urandom), 1'($urandom), $urandom_range(0, 511), $urandom_range(0, 511));
      run_phase(PHASE_WORDS);
      quiet = 1'b1;
      configure(1'($urandom), 1'($urandom), $urandom_range(0, 330), $urandom_range(0, 330));
      run_phase(PHASE_WORDS);

      while (pixel_expect_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("display_ram_window_writer regression: pass");
      else
         $display("display_ram_window_writer regression: fail");
      $finish;
   end

endmodule
